FILE: src/sit_pkg.sv
// Package for the sorted insertion table: sizes, record type, request and state codes.
`default_nettype none
package sit_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port widths of the request and result fields.
  localparam int DAY_W    = 32;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int RIDX_W   = 6;
  localparam int SLOT_W   = 6;
  localparam int FILL_W   = 7;

  // The read path is a two-level registered tree of groups of GRP cells.
  localparam int GRP      = 8;
  localparam int GSEL_W   = $clog2(GRP);
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
  localparam int PAD      = NGRP * GRP;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic signed [DAY_W-1:0] day;
    logic [MONTH_W-1:0]      month;
    logic [YEAR_W-1:0]       year;
  } rec_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } rd_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2
  } sit_state_e;

endpackage
`default_nettype wire

FILE: src/sit_cell.sv
// One slot of the sorted table: holds a record and shifts or takes a new one on insert.
`default_nettype none
module sit_cell (
  input  wire logic                     clk_i,
  input  wire logic [sit_pkg::IDX_W-1:0] cell_idx_i,
  input  wire logic [sit_pkg::CNT_W-1:0] count_i,
  input  wire logic                     ins_i,
  input  wire sit_pkg::rec_t            new_rec_i,
  input  wire sit_pkg::rec_t            left_rec_i,
  input  wire logic                     left_gt_i,
  output      logic                     gt_o,
  output      logic                     take_new_o,
  output      sit_pkg::rec_t            rec_o
);
  import sit_pkg::*;

  rec_t rec_q;
  logic occupied;

  assign occupied   = CNT_W'(cell_idx_i) < count_i;
  assign gt_o       = occupied && ($signed(rec_q.day) > $signed(new_rec_i.day));
  // The new record lands at the first larger key, or at the end of the stored records.
  assign take_new_o = !left_gt_i && (gt_o || (CNT_W'(cell_idx_i) == count_i));
  assign rec_o      = rec_q;

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      if (left_gt_i) begin
        rec_q <= left_rec_i;
      end else if (take_new_o) begin
        rec_q <= new_rec_i;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/sit_rd_tree.sv
// Two-level registered selection tree that reads one cell of the table.
`default_nettype none
module sit_rd_tree (
  input  wire logic                      clk_i,
  input  wire sit_pkg::rd_ctrl_t         ctrl_i,
  input  wire logic [sit_pkg::RIDX_W-1:0] idx_i,
  input  wire sit_pkg::rec_t             recs_i [sit_pkg::PAD],
  output      sit_pkg::rec_t             rec_o
);
  import sit_pkg::*;

  rec_t grp_q [NGRP];
  rec_t grp_d [NGRP];
  rec_t rec_q;
  rec_t rec_d;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (idx_i[GSEL_W-1:0] == GSEL_W'(k)) begin
          grp_d[g] = recs_i[g*GRP + k];
        end
      end
    end
  end

  always_comb begin
    rec_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      if ((32'(idx_i) >> GSEL_W) == 32'(g)) begin
        rec_d = grp_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      grp_q <= grp_d;
    end
    if (ctrl_i.ld2) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule
`default_nettype wire

FILE: src/sorted_insert_table_top.sv
// Top level of the sorted insertion table: cell chain, read tree, control and result registers.
//
// On an insert, every cell compares its key with the new one at once, larger
// keys move up a slot and the new record lands behind any equal keys. Its result appears on the
// result ports, marked by result_valid_o, in the cycle after the request, and busy_o stays low, so
// inserts may follow one another in every cycle. A read walks the two-level registered selection
// tree through ST_RD1 and ST_RD2 with busy_o high, and its result appears when the state returns
// to ST_IDLE; a read holds off new requests until then. A request is accepted when start_i is
// high and busy_o low; each result is shown for one cycle only and must be taken then. Stored
// records are undefined after reset, but only slots below the fill count are ever returned.
`default_nettype none
module sorted_insert_table_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output      logic                        busy_o,
  input  wire logic                        req_type_i,
  input  wire logic signed [sit_pkg::DAY_W-1:0] key_day_i,
  input  wire logic [sit_pkg::MONTH_W-1:0] rec_month_i,
  input  wire logic [sit_pkg::YEAR_W-1:0]  rec_year_i,
  input  wire logic [sit_pkg::RIDX_W-1:0]  read_index_i,
  output      logic                        result_valid_o,
  output      logic [sit_pkg::SLOT_W-1:0]  slot_o,
  output      logic                        full_res_o,
  output      logic                        hit_o,
  output      logic signed [sit_pkg::DAY_W-1:0] out_day_o,
  output      logic [sit_pkg::MONTH_W-1:0] out_month_o,
  output      logic [sit_pkg::YEAR_W-1:0]  out_year_o,
  output      logic [sit_pkg::FILL_W-1:0]  fill_o
);
  import sit_pkg::*;

  sit_state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [RIDX_W-1:0] rd_idx_q;
  logic              valid_q, valid_d;

  logic [SLOT_W-1:0] slot_q;
  logic              full_q;
  logic              hit_q;
  logic [FILL_W-1:0] fill_q;

  logic accept, is_full, ins_go;
  rd_ctrl_t rd_ctrl;

  rec_t new_rec;
  rec_t cell_rec  [CAPACITY];
  rec_t left_rec  [CAPACITY];
  rec_t pad_rec   [PAD];
  rec_t rd_rec;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] left_gt;
  logic [CAPACITY-1:0] take_new;
  logic [IDX_W-1:0]    ins_slot;

  assign new_rec.day   = key_day_i;
  assign new_rec.month = rec_month_i;
  assign new_rec.year  = rec_year_i;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign is_full = (count_q == CNT_W'(CAPACITY));
  assign ins_go  = accept && (req_type_i == REQ_INSERT) && !is_full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_rec[i] = '0;
      assign left_gt[i]  = 1'b0;
    end else begin : g_rest
      assign left_rec[i] = cell_rec[i-1];
      assign left_gt[i]  = gt[i-1];
    end

    sit_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .count_i    (count_q),
      .ins_i      (ins_go),
      .new_rec_i  (new_rec),
      .left_rec_i (left_rec[i]),
      .left_gt_i  (left_gt[i]),
      .gt_o       (gt[i]),
      .take_new_o (take_new[i]),
      .rec_o      (cell_rec[i])
    );
  end

  for (genvar p = 0; p < PAD; p++) begin : g_pad
    if (p < CAPACITY) begin : g_real
      assign pad_rec[p] = cell_rec[p];
    end else begin : g_none
      assign pad_rec[p] = '0;
    end
  end

  // While the table is not full, exactly one cell takes the new record, so its index is an OR of the flagged indices.
  always_comb begin
    ins_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (take_new[i]) begin
        ins_slot = ins_slot | IDX_W'(i);
      end
    end
  end

  sit_rd_tree u_rd_tree (
    .clk_i  (clk_i),
    .ctrl_i (rd_ctrl),
    .idx_i  (rd_idx_q),
    .recs_i (pad_rec),
    .rec_o  (rd_rec)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    valid_d     = 1'b0;
    rd_ctrl.ld1 = 1'b0;
    rd_ctrl.ld2 = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_INSERT) begin
            valid_d = 1'b1;
            if (!is_full) begin
              count_d = count_q + CNT_W'(1);
            end
          end else begin
            state_d = ST_RD1;
          end
        end
      end
      ST_RD1: begin
        rd_ctrl.ld1 = 1'b1;
        state_d     = ST_RD2;
      end
      ST_RD2: begin
        rd_ctrl.ld2 = 1'b1;
        valid_d     = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req_type_i == REQ_READ)) begin
      rd_idx_q <= read_index_i;
    end
    if (accept && (req_type_i == REQ_INSERT)) begin
      slot_q <= is_full ? '0 : SLOT_W'(ins_slot);
      full_q <= is_full;
      hit_q  <= 1'b0;
      fill_q <= FILL_W'(count_d);
    end else if (rd_ctrl.ld2) begin
      slot_q <= '0;
      full_q <= 1'b0;
      hit_q  <= (32'(rd_idx_q) < 32'(count_q));
      fill_q <= FILL_W'(count_q);
    end
  end

  assign result_valid_o = valid_q;
  assign slot_o         = slot_q;
  assign full_res_o     = full_q;
  assign hit_o          = hit_q;
  assign out_day_o      = hit_q ? rd_rec.day   : '0;
  assign out_month_o    = hit_q ? rd_rec.month : '0;
  assign out_year_o     = hit_q ? rd_rec.year  : '0;
  assign fill_o         = fill_q;

  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_INSERT)) |=> result_valid_o)
    else $error("insert request gave no result in the next cycle");

  a_one_landing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_go |-> $onehot(take_new))
    else $error("new record does not land in exactly one cell");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_go |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("fill count did not grow on a stored insert");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_READ)) |=> (busy_o && !result_valid_o) ##1 busy_o ##1
    (!busy_o && result_valid_o))
    else $error("read request did not follow its three-cycle course");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(CAPACITY)))
    else $error("fill count beyond capacity");

endmodule
`default_nettype wire
